### rtl/lfys_pkg.sv
package lfys_pkg;

  localparam int MAX_COUNT = 64;
  localparam int IDX_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int VAL_W = 7;
  localparam int SEED_W = 32;
  localparam int HALF_W = 16;

  localparam logic [SEED_W-1:0] LcgMul = 32'd1103515245;
  localparam logic [SEED_W-1:0] LcgAdd = 32'd12345;
  localparam logic [VAL_W-1:0] MaxCountV = VAL_W'(MAX_COUNT);

  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [VAL_W-1:0]  count;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] element_value;
    logic             last;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [HALF_W-1:0] dividend;
    logic [VAL_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_rsp_t;

endpackage

### rtl/lcg_fisher_yates_shuffle.sv
// Shuffles the values 1..n with a Fisher-Yates pass whose swap indexes come from a 32-bit
// linear congruential generator seeded by the transaction, then streams the n values out with
// the last one flagged. A count above 64 is treated as 64 and a count of zero yields no output.
// Each swap is set by a 16-step restoring modulo unit that produces one quotient bit per cycle,
// plus a multiply, an add, and a read and two writes on the single-write store. A new input
// transaction is taken once the last element of the previous one has been loaded into the
// output register, even if that element is still waiting there.
module lcg_fisher_yates_shuffle
  import lfys_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_FILL     = 10'b00_0000_0010,
    ST_LCG_MUL  = 10'b00_0000_0100,
    ST_LCG_ADD  = 10'b00_0000_1000,
    ST_MOD_GO   = 10'b00_0001_0000,
    ST_MOD_WAIT = 10'b00_0010_0000,
    ST_SW_RD    = 10'b00_0100_0000,
    ST_SW_WR_I  = 10'b00_1000_0000,
    ST_SW_WR_J  = 10'b01_0000_0000,
    ST_EMIT_LD  = 10'b10_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] nm1_r, nm1_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  logic             in_acc, out_load, emit_slot;
  logic [VAL_W-1:0] n_sat;

  logic [VAL_W-1:0] perm_mem [MAX_COUNT];
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;
  logic [VAL_W-1:0] rdata_i_r, rdata_j_r;

  logic              lcg_load, lcg_mul, lcg_add;
  logic [SEED_W-1:0] lcg_state;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  lfys_lcg u_lcg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (lcg_load),
    .seed   (in_data.seed),
    .mul_en (lcg_mul),
    .add_en (lcg_add),
    .state  (lcg_state)
  );

  lfys_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign emit_slot = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_EMIT_LD) && emit_slot;
  assign n_sat     = (in_data.count > MaxCountV) ? MaxCountV : in_data.count;

  assign lcg_load         = in_acc;
  assign lcg_mul          = (state_r == ST_LCG_MUL);
  assign lcg_add          = (state_r == ST_LCG_ADD);
  assign mod_req.start    = (state_r == ST_MOD_GO);
  assign mod_req.dividend = lcg_state[SEED_W-1:HALF_W];
  assign mod_req.divisor  = VAL_W'(idx_r) + 1'b1;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    nm1_nxt   = nm1_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = VAL_W'(idx_r) + 1'b1;
    out_nxt   = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (n_sat != '0)) begin
          nm1_nxt   = IDX_W'(n_sat - 1'b1);
          idx_nxt   = '0;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (idx_r == nm1_r) begin
          if (nm1_r == '0) begin
            idx_nxt   = '0;
            state_nxt = ST_EMIT_LD;
          end else begin
            state_nxt = ST_LCG_MUL;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_LCG_MUL:  state_nxt = ST_LCG_ADD;
      ST_LCG_ADD:  state_nxt = ST_MOD_GO;
      ST_MOD_GO:   state_nxt = ST_MOD_WAIT;
      ST_MOD_WAIT: begin
        if (mod_rsp.done) begin
          state_nxt = ST_SW_RD;
        end
      end
      ST_SW_RD:    state_nxt = ST_SW_WR_I;
      ST_SW_WR_I: begin
        we        = 1'b1;
        wdata     = rdata_j_r;
        state_nxt = ST_SW_WR_J;
      end
      ST_SW_WR_J: begin
        we    = 1'b1;
        waddr = mod_rsp.rem;
        wdata = rdata_i_r;
        if (idx_r == IDX_W'(1)) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT_LD;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ST_LCG_MUL;
        end
      end
      ST_EMIT_LD: begin
        if (emit_slot) begin
          out_nxt.element_value = rdata_i_r;
          out_nxt.last          = (idx_r == nm1_r);
          if (idx_r == nm1_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // On entry and after each index change, the emit state waits until the registered store read is current.
  logic emit_wait_r;

  assign out_valid_nxt = (out_load && !emit_wait_r) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      nm1_r       <= '0;
      out_valid_r <= 1'b0;
      emit_wait_r <= 1'b1;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_EMIT_LD && emit_wait_r) begin
        emit_wait_r <= 1'b0;
      end else begin
        state_r     <= state_nxt;
        idx_r       <= idx_nxt;
        nm1_r       <= nm1_nxt;
        emit_wait_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && !emit_wait_r) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      perm_mem[waddr] <= wdata;
    end
    rdata_i_r <= perm_mem[idx_r];
    rdata_j_r <= perm_mem[mod_rsp.rem];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == ST_MOD_WAIT))
    else $error("modulo result arrived outside the wait state");

  a_swap_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SW_RD) |-> (mod_rsp.rem <= idx_r))
    else $error("swap index exceeds current index");

  a_out_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT_LD))
    else $error("output transaction raised outside the emit state");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !emit_wait_r && (idx_r == nm1_r)) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after the last element");

endmodule

### rtl/lfys_lcg.sv
module lfys_lcg
  import lfys_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [SEED_W-1:0] seed,
  input  logic              mul_en,
  input  logic              add_en,
  output logic [SEED_W-1:0] state
);

  logic [SEED_W-1:0] state_r, state_nxt;
  logic [SEED_W-1:0] prod_r;

  always_comb begin
    state_nxt = state_r;
    if (load) begin
      state_nxt = seed;
    end else if (add_en) begin
      state_nxt = prod_r + LcgAdd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= state_r * LcgMul;
    end
  end

  assign state = state_r;

endmodule

### rtl/lfys_mod.sv
module lfys_mod
  import lfys_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(HALF_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HALF_W-1:0] dvd_r, dvd_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [VAL_W-1:0]  div_r, div_nxt;
  logic [VAL_W-1:0]  trial;

  assign trial = {rem_r[VAL_W-2:0], dvd_r[HALF_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = (trial >= div_r) ? trial - div_r : trial;
      dvd_nxt = {dvd_r[HALF_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(HALF_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[IDX_W-1:0];

endmodule
